// ===== rtl/md4_pkg.sv =====
// Shared types, constants and round tables of the MD4 hash engine.
package md4_pkg;

  // Initial chaining vector, round constants, padding constants and counter limits
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K1 = 32'h5a827999;
  localparam logic [31:0] K2 = 32'h6ed9eba1;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_STEP = 6'd47;
  localparam logic [5:0] LAST_FILL = 6'd63;

  // Input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } md4_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md4_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_EMIT
  } md4_state_t;

  // Source of the byte written into the block store
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } md4_bsel_t;

  typedef struct packed {
    logic      byte_wr;
    md4_bsel_t byte_sel;
    logic      msg_inc;
    logic      work_load;
    logic      step_en;
    logic      chain_add;
    logic      emit_adv;
    logic      iv_load;
  } md4_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       fill_last;
    logic       fill_len;
    logic       step_last;
    logic       emit_last;
  } md4_sts_t;

  // Message word used by a step
  function automatic logic [3:0] word_pick(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] w;
    j = step[3:0];
    case (step[5:4])
      2'd0:    w = j;
      2'd1:    w = {j[1:0], j[3:2]};
      default: w = {j[0], j[1], j[2], j[3]};
    endcase
    return w;
  endfunction

  // Left rotate amount of a step
  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/md4_hash_engine.sv =====
// MD4 hash engine top level: controller plus datapath.
// Bytes arrive one item at a time and are accepted one per cycle while no
// compression runs. A byte that completes a 64-byte block stalls intake while
// the single round unit does one of the 48 steps per cycle and the add state
// then adds the result into the chaining words. A finish item writes the pad
// mark in its accept cycle, then zero and length bytes one per cycle up to the
// block end, with a switch state between the zero and the length bytes. When
// fewer than nine bytes were free, the first block is zero filled and compressed,
// and a second block of 56 zero bytes, the switch state and 8 length bytes
// follows. The engine then presents the four digest words h0..h3 on the
// output, one per accepted item, and reloads the initial vector. No input is
// taken until the last digest word is accepted.
module md4_hash_engine import md4_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  md4_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output md4_out_t out_data
);

  md4_cmd_t cmd;
  md4_sts_t sts;

  md4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_data.kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  md4_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/md4_dp.sv =====
// MD4 datapath: block store, byte and length counters, round unit, chaining words.
module md4_dp import md4_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  md4_cmd_t cmd,
  input  md4_in_t  in_data,
  output md4_sts_t sts,
  output md4_out_t out_data
);

  logic [31:0] block_r [16];
  logic [31:0] chain_r [4];
  logic [31:0] work_r [4];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  emit_idx_r, emit_idx_nxt;

  logic [63:0] bit_len;
  logic [7:0]  wr_byte;
  logic [31:0] fa, fb, fc, fd;
  logic [31:0] f_val, k_val, sum;
  logic [63:0] rot_dbl;

  // Byte to store
  assign bit_len = {msg_r[60:0], 3'b000};
  always_comb begin
    case (cmd.byte_sel)
      BSEL_DATA: wr_byte = in_data.data_byte;
      BSEL_MARK: wr_byte = PAD_MARK;
      BSEL_ZERO: wr_byte = 8'h00;
      default:   wr_byte = bit_len[{fill_r[2:0], 3'b000} +: 8];
    endcase
  end

  // Block store, little-endian byte lanes
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      block_r[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // One compression step
  assign fa = work_r[0];
  assign fb = work_r[1];
  assign fc = work_r[2];
  assign fd = work_r[3];
  always_comb begin
    case (step_r[5:4])
      2'd0: begin
        f_val = (fb & fc) | (~fb & fd);
        k_val = 32'h0;
      end
      2'd1: begin
        f_val = (fb & fc) | (fb & fd) | (fc & fd);
        k_val = K1;
      end
      default: begin
        f_val = fb ^ fc ^ fd;
        k_val = K2;
      end
    endcase
  end
  assign sum = f_val + fa + k_val + block_r[word_pick(step_r)];
  assign rot_dbl = {sum, sum} << rot_amt(step_r);

  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      work_r <= chain_r;
    end else if (cmd.step_en) begin
      work_r[0] <= fd;
      work_r[1] <= rot_dbl[63:32];
      work_r[2] <= fb;
      work_r[3] <= fc;
    end
  end

  // Counters
  always_comb begin
    fill_nxt = fill_r;
    msg_nxt = msg_r;
    step_nxt = step_r;
    emit_idx_nxt = emit_idx_r;
    if (cmd.byte_wr) fill_nxt = fill_r + 6'd1;
    if (cmd.msg_inc) msg_nxt = msg_r + 64'd1;
    if (cmd.step_en) step_nxt = (step_r == LAST_STEP) ? 6'd0 : step_r + 6'd1;
    if (cmd.emit_adv) emit_idx_nxt = emit_idx_r + 2'd1;
    if (cmd.iv_load) begin
      fill_nxt = 6'd0;
      msg_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 6'd0;
      msg_r <= 64'd0;
      step_r <= 6'd0;
      emit_idx_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      msg_r <= msg_nxt;
      step_r <= step_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  // Chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.iv_load) begin
      chain_r[0] <= IV0;
      chain_r[1] <= IV1;
      chain_r[2] <= IV2;
      chain_r[3] <= IV3;
    end else if (cmd.chain_add) begin
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  // Status and result item
  assign sts.fill = fill_r;
  assign sts.fill_last = (fill_r == LAST_FILL);
  assign sts.fill_len = (fill_r == LEN_OFFSET);
  assign sts.step_last = (step_r == LAST_STEP);
  assign sts.emit_last = (emit_idx_r == 2'd3);

  assign out_data.digest_word = chain_r[emit_idx_r];
  assign out_data.word_index = emit_idx_r;
  assign out_data.last_word = (emit_idx_r == 2'd3);

endmodule

// ===== rtl/md4_ctrl.sv =====
// MD4 controller: sequences byte intake, padding, compression and digest output.
module md4_ctrl import md4_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_kind,
  output logic     out_valid,
  input  logic     out_ready,
  input  md4_sts_t sts,
  output md4_cmd_t cmd
);

  md4_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       len_r, len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r <= 1'b0;
      len_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      len_r <= len_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    len_nxt = len_r;
    cmd = '0;
    cmd.byte_sel = BSEL_ZERO;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_wr = 1'b1;
          if (in_kind == KIND_DATA) begin
            cmd.byte_sel = BSEL_DATA;
            cmd.msg_inc = 1'b1;
          end else begin
            cmd.byte_sel = BSEL_MARK;
            fin_nxt = 1'b1;
            state_nxt = ST_PAD;
          end
          if (sts.fill_last) begin
            cmd.work_load = 1'b1;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        if (sts.fill_len) begin
          state_nxt = ST_LEN;
        end else begin
          cmd.byte_wr = 1'b1;
          if (sts.fill_last) begin
            cmd.work_load = 1'b1;
            state_nxt = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        cmd.byte_wr = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        if (sts.fill_last) begin
          len_nxt = 1'b1;
          cmd.work_load = 1'b1;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.step_en = 1'b1;
        if (sts.step_last) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        if (!fin_r) state_nxt = ST_IDLE;
        else if (len_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) begin
            cmd.iv_load = 1'b1;
            fin_nxt = 1'b0;
            len_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Intake and output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while digest pending");

  // Compression runs all 48 steps without a break
  a_comp_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && !sts.step_last) |=> state_r == ST_COMP)
    else $error("compression cut short");

  // Length bytes only go to the last eight byte slots
  a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN) |-> (sts.fill[5:3] == 3'b111))
    else $error("length byte outside its slot");

  // Vector reload only after the fourth digest word
  a_iv_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iv_load |-> (sts.emit_last && fin_r && len_r))
    else $error("early vector reload");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the MD4 hash engine: byte stream in, digest words out.
module testbench;
  import md4_pkg::*;

  localparam int TIME_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 410;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AT_WORD = 24;
  localparam int LONG_HOLD = 600;
  localparam int PAUSE_AT_MSG = 4;

  // Per-round left rotate amounts, indexed by step modulo 4
  localparam int SHIFTS [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
  // Message lengths around the one-block and two-block padding boundaries
  localparam int PAD_BOUNDARY_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  // Known digests (h0..h3) of short test strings
  localparam logic [0:3][31:0] EMPTY_DIGEST =
    {32'he0cfd631, 32'h31e96ad1, 32'hd7593cb7, 32'hc089c0e0};
  localparam logic [0:3][31:0] A_DIGEST =
    {32'hb32ce5bd, 32'h463ee31d, 32'hfb055e24, 32'h24fbd6db};
  localparam logic [0:3][31:0] ABC_DIGEST =
    {32'h7a0148a4, 32'h52d821af, 32'he80ac15f, 32'h9d72a67a};

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic             has_digest;
    logic [0:3][31:0] digest;
  } script_row_t;

  // Directed items: empty message, ignored byte on finish, short strings, byte extremes
  script_row_t directed_items [18] = '{
    '{KIND_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
    '{KIND_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
    '{KIND_DATA,   8'h61, 1'b0, '0},
    '{KIND_FINISH, 8'h00, 1'b1, A_DIGEST},
    '{KIND_DATA,   8'h61, 1'b0, '0},
    '{KIND_DATA,   8'h62, 1'b0, '0},
    '{KIND_DATA,   8'h63, 1'b0, '0},
    '{KIND_FINISH, 8'h5a, 1'b1, ABC_DIGEST},
    '{KIND_DATA,   8'h00, 1'b0, '0},
    '{KIND_DATA,   8'hff, 1'b0, '0},
    '{KIND_DATA,   8'h80, 1'b0, '0},
    '{KIND_DATA,   8'h7f, 1'b0, '0},
    '{KIND_DATA,   8'h01, 1'b0, '0},
    '{KIND_FINISH, 8'haa, 1'b0, '0},
    '{KIND_DATA,   8'hff, 1'b0, '0},
    '{KIND_FINISH, 8'h55, 1'b0, '0},
    '{KIND_DATA,   8'h00, 1'b0, '0},
    '{KIND_FINISH, 8'hff, 1'b0, '0}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  md4_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  md4_out_t out_data;

  // Predictor state
  logic [31:0] chain_h [4];
  logic [31:0] block_w [16];
  int          fill_cnt;
  logic [63:0] msg_len;

  md4_out_t    pending_digest_words [$];
  // Directed finish rows, in the order they are sent
  script_row_t finish_rows [$];
  int          mismatches;

  md4_hash_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Fresh message: initial vector, empty block, zero length
  function automatic void restart_message();
    chain_h[0] = IV0;
    chain_h[1] = IV1;
    chain_h[2] = IV2;
    chain_h[3] = IV3;
    fill_cnt = 0;
    msg_len = '0;
  endfunction

  function automatic void put_byte(int pos, logic [7:0] value);
    block_w[pos / 4][8 * (pos % 4) +: 8] = value;
  endfunction

  // 48-step compression of the current block, added into the chain
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, k, t;
    int step, r, j, w, s;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (step = 0; step < 48; step++) begin
      r = step / 16;
      j = step % 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          k = '0;
          w = j;
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = K1;
          w = (j % 4) * 4 + j / 4;
        end
        default: begin
          f = b ^ c ^ d;
          k = K2;
          // bit-reversed step index
          w = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        end
      endcase
      s = SHIFTS[r][step % 4];
      t = a + f + k + block_w[w];
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
  endfunction

  // Absorb one item; returns 1 when a finish has left the digest in chain_h
  function automatic bit md4_absorb(md4_in_t item);
    logic [63:0] bit_len;
    if (item.kind == KIND_DATA) begin
      put_byte(fill_cnt, item.data_byte);
      fill_cnt++;
      msg_len++;
      if (fill_cnt == 64) begin
        compress_block();
        fill_cnt = 0;
      end
      return 1'b0;
    end
    // padding: mark, zeros, then the bit length in the last eight bytes
    put_byte(fill_cnt, PAD_MARK);
    fill_cnt++;
    if (fill_cnt > int'(LEN_OFFSET)) begin
      while (fill_cnt < 64) begin
        put_byte(fill_cnt, 8'h00);
        fill_cnt++;
      end
      compress_block();
      fill_cnt = 0;
    end
    while (fill_cnt < int'(LEN_OFFSET)) begin
      put_byte(fill_cnt, 8'h00);
      fill_cnt++;
    end
    bit_len = msg_len << 3;
    block_w[14] = bit_len[31:0];
    block_w[15] = bit_len[63:32];
    compress_block();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // Input side monitor: predict on every accepted item, typed digest for directed rows that carry one
  always @(posedge clk) begin
    script_row_t      row;
    logic [0:3][31:0] want_words;
    if (!rst_n) begin
      restart_message();
    end else if (in_valid && in_ready) begin
      if (md4_absorb(in_data)) begin
        want_words = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
        if (finish_rows.size() != 0) begin
          row = finish_rows.pop_front();
          if (row.has_digest) want_words = row.digest;
        end
        for (int i = 0; i < 4; i++) begin
          pending_digest_words.push_back('{digest_word: want_words[i],
                                           word_index: 2'(i),
                                           last_word: (i == 3)});
        end
        restart_message();
      end
    end
  end

  // Result side monitor: compare with the oldest expected word
  always @(posedge clk) begin
    md4_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest_words.size() == 0) begin
        report_mismatch("unexpected digest word", out_data.digest_word, '0);
      end else begin
        want = pending_digest_words.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Offer one item after a random gap (none when quick), return at the edge where it is taken
  task automatic send_item(md4_in_t item, bit quick);
    int gap;
    gap = quick ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 8);
      2:       return PAD_BOUNDARY_LENS[$urandom_range(0, 8)];
      default: return $urandom_range(0, 130);
    endcase
  endfunction

  // Sender: directed table, then random messages
  initial begin
    int sent, len, msg_idx;
    bit quick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_items[i]) begin
      if (directed_items[i].kind == KIND_FINISH) finish_rows.push_back(directed_items[i]);
      send_item({directed_items[i].kind, directed_items[i].data_byte}, 1'b0);
    end

    sent = 0;
    msg_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      // once, let the engine drain completely before the next message
      if (msg_idx == PAUSE_AT_MSG) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_digest_words.size() != 0);
      end
      len = pick_length();
      if (len > RANDOM_ITEMS - sent - 1) len = RANDOM_ITEMS - sent - 1;
      quick = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++)
        send_item({KIND_DATA, 8'($urandom_range(0, 255))}, quick);
      send_item({KIND_FINISH, 8'($urandom_range(0, 255))}, quick);
      sent += len + 1;
      msg_idx++;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_digest_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_digest_words.size() == 0) begin
      $display("[md4_hash_engine] OK");
    end else begin
      $display("[md4_hash_engine] ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int stall, taken;
    out_ready = 1'b0;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HOLD_AT_WORD) stall = LONG_HOLD;
      else if ((taken / 24) % 3 == 1) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Hang guard
  initial begin
    #TIME_LIMIT;
    $display("[md4_hash_engine] ERROR");
    $finish;
  end

endmodule
